>>> rtl/smas_pkg.sv
`default_nettype none
package smas_pkg;

  // Mix store geometry.
  localparam int PAINT_SLOTS = 4096;
  localparam int SLOT_W = $clog2(PAINT_SLOTS);

  // Request opcodes.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ACC   = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MASTER_VOLUME = 2'd0;
  localparam logic [1:0] REG_SAMPLE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_STEREO        = 2'd2;
  localparam logic [1:0] REG_RING_LOG2     = 2'd3;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_LOAD   = 4'd1;
  localparam logic [3:0] ST_GAIN_L = 4'd2;
  localparam logic [3:0] ST_PROD_L = 4'd3;
  localparam logic [3:0] ST_GAIN_R = 4'd4;
  localparam logic [3:0] ST_PROD_R = 4'd5;
  localparam logic [3:0] ST_WRITE  = 4'd6;
  localparam logic [3:0] ST_EMIT_L = 4'd7;
  localparam logic [3:0] ST_EMIT_R = 4'd8;

  // Takes sum >> 8, clamps it to 16-bit signed, and in 8-bit mode turns it
  // into (v >> 8) + 128, which is the high byte with its top bit flipped.
  function automatic logic [15:0] sat_value(input logic [31:0] sum, input logic wide16);
    logic [23:0] v;
    logic [15:0] s;
    v = sum[31:8];
    if (!v[23] && (|v[22:15])) begin
      s = 16'h7fff;
    end else if (v[23] && !(&v[22:15])) begin
      s = 16'h8000;
    end else begin
      s = v[15:0];
    end
    if (wide16) begin
      sat_value = s;
    end else begin
      sat_value = {8'h00, ~s[15], s[14:8]};
    end
  endfunction

  // Ring mask from its log2 size; sizes above 16 bits act as 16.
  function automatic logic [15:0] ring_mask(input logic [4:0] lg);
    if (lg[4]) begin
      ring_mask = 16'hffff;
    end else begin
      ring_mask = (16'd1 << lg[3:0]) - 16'd1;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/stereo_mix_accumulate_saturate_unit.sv
// Clear writes on acceptance; accumulate runs load, two gain and two sample
// products, then write-back; drain runs load, then one emit state per result,
// held while stalled; in_ready is high only while the sequencer is idle.
// Accumulate time is set by the single shared multiplier, used four times
// (two gain products, two sample products) before the slot is written back.
// Reset restores the registers to volume 255, 16-bit, stereo, ring 2^14;
// the mix store is not cleared, so each slot must be cleared before use.
`default_nettype none
module stereo_mix_accumulate_saturate_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [7:0]                  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  opcode,
  input  wire logic [smas_pkg::SLOT_W-1:0] slot,
  input  wire logic signed [15:0]          sample,
  input  wire logic [7:0]                  left_gain,
  input  wire logic [7:0]                  right_gain,
  input  wire logic [15:0]                 play_time,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [15:0]               out_value,
  output logic [15:0]                      ring_index,
  output logic                             last
);

  // Configuration registers.
  logic [7:0] master_volume;
  logic       sample_width_mode;
  logic       stereo_mode;
  logic [4:0] ring_size_log2;

  // Sequencer and latched request.
  logic [3:0]                  state;
  logic [3:0]                  state_next;
  logic [1:0]                  op_r;
  logic [smas_pkg::SLOT_W-1:0] slot_r;
  logic signed [15:0]          sample_r;
  logic [7:0]                  lg_r;
  logic [7:0]                  rg_r;
  logic [15:0]                 time_r;

  // Working datapath.
  logic [15:0]        gain;
  logic signed [32:0] prod;
  logic [31:0]        lsum;
  logic [31:0]        rsum;
  logic [31:0]        prod_sh;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] mres;

  // Mix store.
  logic [63:0] mem [smas_pkg::PAINT_SLOTS];
  logic [63:0] rdata;
  logic        wr_en;
  logic [smas_pkg::SLOT_W-1:0] wr_addr;
  logic [63:0] wr_data;

  // Ring position of the left lane.
  logic [15:0] t_sum;
  logic [15:0] base;
  logic [15:0] mask;
  logic        out_free;
  logic        in_accept;

  assign in_ready  = (state == smas_pkg::ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Shared multiplier: gain products and sample products take turns.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      smas_pkg::ST_GAIN_L: begin
        mul_a = {9'd0, lg_r};
        mul_b = {9'd0, master_volume};
      end
      smas_pkg::ST_GAIN_R: begin
        mul_a = {9'd0, rg_r};
        mul_b = {9'd0, master_volume};
      end
      smas_pkg::ST_PROD_L, smas_pkg::ST_PROD_R: begin
        mul_a = {sample_r[15], sample_r};
        mul_b = {1'b0, gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mres    = mul_a * mul_b;
  assign prod_sh = {{7{prod[32]}}, prod[32:8]};

  // Ring index arithmetic.
  assign t_sum = time_r + {{(16 - smas_pkg::SLOT_W){1'b0}}, slot_r};
  assign base  = stereo_mode ? {t_sum[14:0], 1'b0} : t_sum;
  assign mask  = smas_pkg::ring_mask(ring_size_log2);

  // Store write port: clear writes at once, accumulate writes back at the end.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = {rsum + prod_sh, lsum};
    if (in_accept && opcode == smas_pkg::OP_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = slot;
      wr_data = '0;
    end else if (state == smas_pkg::ST_WRITE) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[slot];
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      smas_pkg::ST_IDLE: begin
        if (in_accept && (opcode == smas_pkg::OP_ACC || opcode == smas_pkg::OP_DRAIN)) begin
          state_next = smas_pkg::ST_LOAD;
        end
      end
      smas_pkg::ST_LOAD: begin
        state_next = (op_r == smas_pkg::OP_ACC) ? smas_pkg::ST_GAIN_L : smas_pkg::ST_EMIT_L;
      end
      smas_pkg::ST_GAIN_L: state_next = smas_pkg::ST_PROD_L;
      smas_pkg::ST_PROD_L: state_next = smas_pkg::ST_GAIN_R;
      smas_pkg::ST_GAIN_R: state_next = smas_pkg::ST_PROD_R;
      smas_pkg::ST_PROD_R: state_next = smas_pkg::ST_WRITE;
      smas_pkg::ST_WRITE:  state_next = smas_pkg::ST_IDLE;
      smas_pkg::ST_EMIT_L: begin
        if (out_free) begin
          state_next = stereo_mode ? smas_pkg::ST_EMIT_R : smas_pkg::ST_IDLE;
        end
      end
      smas_pkg::ST_EMIT_R: begin
        if (out_free) begin
          state_next = smas_pkg::ST_IDLE;
        end
      end
      default: state_next = smas_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= smas_pkg::ST_IDLE;
      out_valid         <= 1'b0;
      master_volume     <= 8'd255;
      sample_width_mode <= 1'b1;
      stereo_mode       <= 1'b1;
      ring_size_log2    <= 5'd14;
    end else begin
      state <= state_next;
      if ((state == smas_pkg::ST_EMIT_L || state == smas_pkg::ST_EMIT_R) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          smas_pkg::REG_MASTER_VOLUME: master_volume     <= cfg_data;
          smas_pkg::REG_SAMPLE_WIDTH:  sample_width_mode <= cfg_data[0];
          smas_pkg::REG_STEREO:        stereo_mode       <= cfg_data[0];
          smas_pkg::REG_RING_LOG2:     ring_size_log2    <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Request latch and datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= opcode;
      slot_r   <= slot;
      sample_r <= sample;
      lg_r     <= left_gain;
      rg_r     <= right_gain;
      time_r   <= play_time;
    end
    case (state)
      smas_pkg::ST_LOAD: begin
        lsum <= rdata[31:0];
        rsum <= rdata[63:32];
      end
      smas_pkg::ST_GAIN_L: gain <= mres[15:0];
      smas_pkg::ST_PROD_L: prod <= mres[32:0];
      smas_pkg::ST_GAIN_R: begin
        lsum <= lsum + prod_sh;
        gain <= mres[15:0];
      end
      smas_pkg::ST_PROD_R: prod <= mres[32:0];
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == smas_pkg::ST_EMIT_L && out_free) begin
      out_value  <= smas_pkg::sat_value(lsum, sample_width_mode);
      ring_index <= base & mask;
      last       <= !stereo_mode;
    end else if (state == smas_pkg::ST_EMIT_R && out_free) begin
      out_value  <= smas_pkg::sat_value(rsum, sample_width_mode);
      ring_index <= (base | 16'd1) & mask;
      last       <= 1'b1;
    end
  end

endmodule
`default_nettype wire
